/* hdl/bdcd_pkg.sv */
`timescale 1ns / 1ps

package bdcd_pkg;

  localparam int unsigned DebounceW = 8;
  localparam int unsigned TimerW    = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_COUNT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CLICK_GAP_TICKS  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_TICKS = 2'd2;

  localparam logic [DebounceW-1:0] DEBOUNCE_RESET   = 8'd3;
  localparam logic [TimerW-1:0]    CLICK_GAP_RESET  = 13'd20;
  localparam logic [TimerW-1:0]    LONG_PRESS_RESET = 13'd200;

  localparam logic [1:0] KIND_SHORT  = 2'd0;
  localparam logic [1:0] KIND_DOUBLE = 2'd1;
  localparam logic [1:0] KIND_TRIPLE = 2'd2;
  localparam logic [1:0] KIND_LONG   = 2'd3;

  // sampled level: released, pressed, or nothing sampled since an edge
  localparam logic [1:0] LVL_RELEASED = 2'd0;
  localparam logic [1:0] LVL_NONE     = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_REL1  = 6'b000010,
    ST_PRS1  = 6'b000100,
    ST_REL2  = 6'b001000,
    ST_PRS2  = 6'b010000,
    ST_WIDLE = 6'b100000
  } gesture_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } kind_t;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_count;
    logic [TimerW-1:0]    click_gap_ticks;
    logic [TimerW-1:0]    long_press_ticks;
  } cfg_t;

  typedef struct packed {
    gesture_t             gesture;
    logic [1:0]           sampled;
    logic                 settled;
    logic [DebounceW-1:0] debounce_left;
    logic [TimerW-1:0]    timer;
    kind_t                pending;
  } key_state_t;

  localparam key_state_t KEY_STATE_RESET = '{
    gesture:       ST_IDLE,
    sampled:       LVL_NONE,
    settled:       1'b0,
    debounce_left: '0,
    timer:         '0,
    pending:       '{valid: 1'b0, code: KIND_SHORT}
  };

  function automatic gesture_t next_gesture(gesture_t cur, logic timeout);
    gesture_t nx;
    case (cur)
      ST_REL1:  nx = timeout ? ST_WIDLE : ST_PRS1;
      ST_PRS1:  nx = timeout ? ST_IDLE  : ST_REL2;
      ST_REL2:  nx = timeout ? ST_WIDLE : ST_PRS2;
      ST_PRS2:  nx = timeout ? ST_IDLE  : ST_WIDLE;
      ST_WIDLE: nx = timeout ? ST_WIDLE : ST_IDLE;
      default:  nx = timeout ? ST_IDLE  : ST_REL1;
    endcase
    return nx;
  endfunction

  function automatic kind_t event_kind(gesture_t cur, logic timeout);
    kind_t k;
    k = '{valid: 1'b0, code: KIND_SHORT};
    case (cur)
      ST_REL1: if (timeout) k = '{valid: 1'b1, code: KIND_LONG};
      ST_PRS1: if (timeout) k = '{valid: 1'b1, code: KIND_SHORT};
      ST_REL2: if (timeout) k = '{valid: 1'b1, code: KIND_DOUBLE};
      ST_PRS2: begin
        k.valid = 1'b1;
        k.code  = timeout ? KIND_DOUBLE : KIND_TRIPLE;
      end
      default: k = '{valid: 1'b0, code: KIND_SHORT};
    endcase
    return k;
  endfunction

  function automatic logic gesture_active(gesture_t cur);
    logic act;
    case (cur)
      ST_REL1, ST_PRS1, ST_REL2, ST_PRS2, ST_WIDLE: act = 1'b1;
      default: act = 1'b0;
    endcase
    return act;
  endfunction

endpackage

/* hdl/button_debounce_click_detector.sv */
`timescale 1ns / 1ps

// Debounce and click detection for NUM_KEYS buttons. Each transfer on the tick
// channel is one scan tick of one key; keys at or above NUM_KEYS are dropped.
// A new tick is taken every clock while tick_stall is low; its report (short,
// double, triple or long), if the tick ends a gesture, is registered and offered
// once the tick leaves the held-tick register. Read, update and write-back of the
// key's state record happen together, so ticks for the same key may follow freely.

module button_debounce_click_detector
  import bdcd_pkg::*;
#(
  parameter int NUM_KEYS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  logic [1:0]          key_index,
  input  logic                pressed_level,
  input  logic                edge_seen,
  output logic                report_valid,
  input  logic                report_stall,
  output logic [1:0]          report_key,
  output logic [1:0]          click_kind
);

  localparam int KeyIdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  cfg_t       cfg;
  key_state_t key_state [NUM_KEYS];

  logic       held_valid;
  logic [1:0] held_key;
  logic       held_level;
  logic       held_edge;

  logic               advance;
  logic               held_fire;
  logic               in_range;
  logic [KeyIdxW-1:0] idx;
  key_state_t         cur;
  key_state_t         nxt;
  logic               step_report;
  logic [1:0]         step_kind;

  assign advance    = !report_valid || !report_stall;
  assign held_fire  = held_valid && advance;
  assign tick_stall = held_valid && !advance;
  assign in_range   = (32'(held_key) < NUM_KEYS);
  assign idx        = KeyIdxW'(held_key);
  assign cur        = key_state[idx];

  bdcd_key_update u_update (
    .cur       (cur),
    .level     (held_level),
    .edge_seen (held_edge),
    .cfg       (cfg),
    .nxt       (nxt),
    .report    (step_report),
    .kind      (step_kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_count   <= DEBOUNCE_RESET;
      cfg.click_gap_ticks  <= CLICK_GAP_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE_COUNT:   cfg.debounce_count   <= cfg_data[DebounceW-1:0];
        REG_CLICK_GAP_TICKS:  cfg.click_gap_ticks  <= cfg_data[TimerW-1:0];
        REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data[TimerW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      report_valid <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_state[k] <= KEY_STATE_RESET;
      end
    end else begin
      if (!tick_stall) begin
        held_valid <= tick_valid;
      end
      if (advance) begin
        report_valid <= held_fire && in_range && step_report;
      end
      if (held_fire && in_range) begin
        key_state[idx] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!tick_stall) begin
      held_key   <= key_index;
      held_level <= pressed_level;
      held_edge  <= edge_seen;
    end
    if (advance) begin
      report_key <= held_key;
      click_kind <= step_kind;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> held_valid && report_valid)
    else $error("tick stalled without a held tick behind a waiting report");

  assert property (@(posedge clk) disable iff (rst)
    $rose(report_valid) |-> $past(held_fire) && $past(in_range))
    else $error("report raised without a processed tick");

  assert property (@(posedge clk) disable iff (rst)
    held_fire && in_range && step_report |-> nxt.gesture == ST_IDLE)
    else $error("report given while gesture not back in idle");

  assert property (@(posedge clk) disable iff (rst)
    held_fire && in_range && nxt.gesture == ST_IDLE |-> nxt.timer == '0 && !nxt.pending.valid)
    else $error("idle key left with running timer or pending kind");
`endif

endmodule

/* hdl/bdcd_key_update.sv */
`timescale 1ns / 1ps

module bdcd_key_update
  import bdcd_pkg::*;
(
  input  key_state_t cur,
  input  logic       level,
  input  logic       edge_seen,
  input  cfg_t       cfg,
  output key_state_t nxt,
  output logic       report,
  output logic [1:0] kind
);

  logic [1:0] samp;
  logic       accept;
  logic       timeout;
  logic       transition;
  gesture_t   nx;
  kind_t      ev_kind;
  kind_t      pend;

  always_comb begin
    samp    = edge_seen ? LVL_NONE : cur.sampled;
    nxt     = cur;
    accept  = 1'b0;
    timeout = 1'b0;
    report  = 1'b0;
    kind    = cur.pending.code;
    nx      = cur.gesture;
    ev_kind = '{valid: 1'b0, code: KIND_SHORT};
    pend    = cur.pending;

    if ({1'b0, level} != samp) begin
      nxt.sampled       = {1'b0, level};
      nxt.debounce_left = cfg.debounce_count;
      accept            = (cfg.debounce_count == '0);
    end else if (cur.debounce_left != '0) begin
      nxt.sampled       = samp;
      nxt.debounce_left = cur.debounce_left - 1'b1;
      accept            = (cur.debounce_left == DebounceW'(1));
    end else begin
      nxt.sampled = samp;
      if (gesture_active(cur.gesture)) begin
        if (cur.timer <= TimerW'(1)) begin
          timeout = 1'b1;
        end else begin
          nxt.timer = cur.timer - 1'b1;
        end
      end
    end

    transition = accept && (cur.settled != level);
    if (transition) begin
      nxt.settled = level;
    end

    if (transition || timeout) begin
      nx      = next_gesture(cur.gesture, timeout);
      ev_kind = event_kind(cur.gesture, timeout);
      if (ev_kind.valid) begin
        pend = ev_kind;
      end
      nxt.gesture = nx;
      nxt.pending = pend;
      nxt.timer   = (nx == ST_REL1) ? cfg.long_press_ticks : cfg.click_gap_ticks;
      if (nx == ST_IDLE) begin
        report            = pend.valid;
        kind              = pend.code;
        nxt.timer         = '0;
        nxt.pending.valid = 1'b0;
      end
    end
  end

endmodule
